// ===== hw/rtl/rdss_pkg.sv =====
// rdss_pkg: shared types and constants of the rice decoder for signed samples
// holds the sample record exchanged between the byte front end, the queue and the drain
// no dependencies
`default_nettype none

package rdss_pkg;

  localparam int unsigned RunBits    = 16;
  localparam int unsigned RemBits    = 15;
  localparam int unsigned KBits      = 4;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned MaxOut     = 4;
  localparam int unsigned CntBits    = 3;
  localparam int unsigned IdxBits    = 2;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QPtrBits   = 1;
  localparam logic [KBits-1:0] RiceKReset = 4'd1;

  typedef struct packed {
    logic               in_rem;
    logic [RunBits-1:0] run;
    logic [RemBits-1:0] acc;
    logic [KBits-1:0]   left;
    logic               ovf;
  } rdss_dec_t;

  typedef struct packed {
    logic [RunBits-1:0] run;
    logic [RemBits-1:0] rem;
    logic               ovf;
  } rdss_ent_t;

  typedef struct packed {
    logic [CntBits-1:0]       cnt;
    rdss_ent_t [MaxOut-1:0]   ent;
  } rdss_rec_t;

  function automatic logic [KBits-1:0] eff_k(input logic [KBits-1:0] k);
    return (k == '0) ? KBits'(1) : k;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rdss_front.sv =====
// rdss_front: takes one coded byte per item and decodes its 8 bits msb first
// emits a record of up to four finished samples (run, remainder, overflow)
// depends on rdss_pkg
`default_nettype none

module rdss_front import rdss_pkg::*; #(
  parameter int unsigned SampleBits = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [KBits-1:0]    rice_k_i,
  input  wire logic                clr_i,
  input  wire logic                in_valid_i,
  input  wire logic [ByteBits-1:0] in_byte_i,
  output      logic                in_ready_o,
  input  wire logic                full_i,
  output      logic                push_o,
  output      rdss_rec_t           rec_o
);

  rdss_dec_t st_q, st_d;
  logic [KBits-1:0]      k_eff;
  logic [SampleBits-1:0] cap_w;
  logic [SampleBits-1:0] cap_hi;
  logic [RunBits-1:0]    cap;
  logic [CntBits-1:0]    n;
  logic                  accept;

  assign k_eff  = eff_k(rice_k_i);
  assign cap_w  = {SampleBits{1'b1}} >> k_eff;
  assign cap_hi = cap_w >> RunBits;
  assign cap    = (|cap_hi) ? {RunBits{1'b1}} : RunBits'(cap_w);

  always_comb begin
    logic bit_v;
    st_d  = st_q;
    n     = '0;
    rec_o = '0;
    for (int b = ByteBits - 1; b >= 0; b--) begin
      bit_v = in_byte_i[b];
      if (!st_d.in_rem) begin
        if (!bit_v) begin
          if (st_d.run >= cap) begin
            st_d.run = cap;
            st_d.ovf = 1'b1;
          end else begin
            st_d.run = st_d.run + RunBits'(1);
          end
        end else begin
          st_d.in_rem = 1'b1;
          st_d.left   = k_eff;
          st_d.acc    = '0;
        end
      end else begin
        st_d.acc = {st_d.acc[RemBits-2:0], bit_v};
        if (st_d.left != '0) begin
          st_d.left = st_d.left - KBits'(1);
        end
        if (st_d.left == '0) begin
          if (n < CntBits'(MaxOut)) begin
            rec_o.ent[n[IdxBits-1:0]] = '{run: st_d.run, rem: st_d.acc, ovf: st_d.ovf};
            n = n + CntBits'(1);
          end
          st_d = '0;
        end
      end
    end
    rec_o.cnt = n;
  end

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && (n != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (clr_i) begin
      st_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rdss_queue.sv =====
// rdss_queue: short fifo of sample records between the byte front end and the drain
// depends on rdss_pkg
`default_nettype none

module rdss_queue import rdss_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire rdss_rec_t rec_i,
  output      logic      full_o,
  output      logic      valid_o,
  input  wire logic      pop_i,
  output      rdss_rec_t head_o
);

  rdss_rec_t mem_q [QDepth];
  logic [QPtrBits-1:0] wr_q, rd_q;
  logic [QPtrBits:0]   cnt_q;

  assign full_o  = (cnt_q == (QPtrBits + 1)'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrBits'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrBits'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPtrBits + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPtrBits + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rdss_back.sv =====
// rdss_back: drains one sample per cycle from the head record when not stalled
// rebuilds the mapped value, undoes the sign folding, holds the output register
// depends on rdss_pkg
`default_nettype none

module rdss_back import rdss_pkg::*; #(
  parameter int unsigned SampleBits = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [KBits-1:0]      rice_k_i,
  input  wire logic                  q_valid_i,
  input  wire rdss_rec_t             q_head_i,
  output      logic                  pop_o,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [SampleBits-1:0] sample_o,
  output      logic                  ovf_o,
  output      logic                  last_o
);

  localparam int unsigned VBits = RunBits + RemBits + 2;

  logic [IdxBits-1:0]    idx_q;
  logic                  out_valid_q;
  logic [SampleBits-1:0] sample_q;
  logic                  ovf_q, last_q;
  rdss_ent_t             ent;
  logic [VBits-1:0]      v;
  logic [VBits-1:0]      h;
  logic [SampleBits-1:0] hs, s;
  logic                  last, fire;

  assign ent  = q_head_i.ent[idx_q];
  assign v    = (VBits'(ent.run) << eff_k(rice_k_i)) + VBits'(ent.rem);
  assign h    = (v + VBits'(v[0])) >> 1;
  assign hs   = SampleBits'(h);
  assign s    = v[0] ? (~hs + SampleBits'(1)) : hs;
  assign last = ({1'b0, idx_q} + CntBits'(1)) == q_head_i.cnt;
  assign fire = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = fire && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        idx_q       <= last ? '0 : idx_q + IdxBits'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      sample_q <= s;
      ovf_q    <= ent.ovf;
      last_q   <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign ovf_o       = ovf_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rice_decoder_signed_samples.sv =====
// rice_decoder_signed_samples: top level of the rice decoder for signed samples
// instantiates rdss_front, rdss_queue and rdss_back; depends on rdss_pkg
//
// channel  dir  handshake                   payload
// s_axis   in   s_axis_tvalid/s_axis_tready tdata[7:0] = stream_byte
// m_axis   out  m_axis_tvalid/m_axis_tready tdata = sample, tuser = run_overflow,
//                                           tlast = last_in_byte
// cfg      in   cfg_we_i                    cfg_wdata_i[3:0] = rice_k
//
// a byte is decoded in the cycle it is taken; its samples leave the drain one
// per cycle while records are queued and the output is not stalled
// a two-record queue lets the byte side run ahead while the output is stalled
// reset sets rice_k to 1 and clears all decode state; a cfg write also clears it
`default_nettype none

module rice_decoder_signed_samples import rdss_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  input  wire logic [ByteBits-1:0]                 s_axis_tdata,  // [7:0] stream_byte
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output      logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,  // sample, zero padded
  output      logic                                m_axis_tuser,  // [0] run_overflow
  output      logic                                m_axis_tlast,
  input  wire logic                                cfg_we_i,
  input  wire logic [KBits-1:0]                    cfg_wdata_i
);

  localparam int unsigned TdataBits = ((SAMPLE_BITS + 7) / 8) * 8;

  logic [KBits-1:0]       rice_k_q;
  logic                   q_push, q_full, q_valid, q_pop;
  rdss_rec_t              q_rec, q_head;
  logic [SAMPLE_BITS-1:0] sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rice_k_q <= RiceKReset;
    end else if (cfg_we_i) begin
      rice_k_q <= cfg_wdata_i;
    end
  end

  rdss_front #(.SampleBits(SAMPLE_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rice_k_i   (rice_k_q),
    .clr_i      (cfg_we_i),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .full_i     (q_full),
    .push_o     (q_push),
    .rec_o      (q_rec)
  );

  rdss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (q_rec),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .head_o  (q_head)
  );

  rdss_back #(.SampleBits(SAMPLE_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rice_k_i    (rice_k_q),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sample_o    (sample),
    .ovf_o       (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = TdataBits'(sample);

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("record pushed into full queue");

  a_head_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid |-> (q_head.cnt != '0 && q_head.cnt <= CntBits'(MaxOut)))
    else $error("queued record with bad sample count");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== bench/rice_decoder_signed_samples_test.sv =====
// self-checking bench for rice_decoder_signed_samples: feeds coded bytes over the
// stream input and checks every decoded sample against an in-bench rice decoder
// depends on rdss_pkg and the rice_decoder_signed_samples rtl
`timescale 1ns / 1ps

module rice_decoder_signed_samples_test;
  import rdss_pkg::*;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned LongHoldCycles = 150;
  localparam int unsigned LongHoldBacklog = 12;

  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic                  ovf;
    logic                  last;
  } sample_exp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ByteBits-1:0]   s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [SampleBits-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we_i = 1'b0;
  logic [KBits-1:0]      cfg_wdata_i = '0;

  // decoder state kept by the bench
  logic [KBits-1:0]   rice_k_cur = RiceKReset;
  logic               dec_in_rem = 1'b0;
  logic [RunBits-1:0] dec_run = '0;
  logic [RemBits-1:0] dec_acc = '0;
  logic [KBits-1:0]   dec_left = '0;
  logic               dec_ovf = 1'b0;

  logic [ByteBits-1:0] pending_bytes[$];
  sample_exp_t         expected_samples[$];
  logic                idle_on = 1'b1;
  logic                long_hold_done = 1'b0;
  int                  send_gap = 0;
  int                  recv_hold = 0;
  int                  samples_seen = 0;
  int                  mismatch_count = 0;
  int                  cycle_count = 0;
  sample_exp_t         want;

  rice_decoder_signed_samples #(
    .SAMPLE_BITS(SampleBits)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string field, input int got, input int exp_val);
    $display("mismatch on %s of sample %0d: got %0d, expected %0d",
             field, samples_seen, got, exp_val);
    mismatch_count++;
  endtask

  task automatic clear_decode_state();
    dec_in_rem = 1'b0;
    dec_run = '0;
    dec_acc = '0;
    dec_left = '0;
    dec_ovf = 1'b0;
  endtask

  // walks one byte msb first and queues the samples it completes
  task automatic decode_byte(input logic [ByteBits-1:0] code);
    logic [KBits-1:0]   k;
    logic [RunBits-1:0] cap;
    logic [31:0]        mapped;
    logic [31:0]        half;
    sample_exp_t        found[MaxOut];
    int                 n;
    int                 i;
    k = (rice_k_cur == '0) ? KBits'(1) : rice_k_cur;
    cap = 16'hFFFF >> k;
    n = 0;
    for (i = ByteBits - 1; i >= 0; i--) begin
      if (!dec_in_rem) begin
        if (!code[i]) begin
          if (dec_run >= cap) begin
            dec_run = cap;
            dec_ovf = 1'b1;
          end else begin
            dec_run = dec_run + 1'b1;
          end
        end else begin
          dec_in_rem = 1'b1;
          dec_left = k;
          dec_acc = '0;
        end
      end else begin
        dec_acc = {dec_acc[RemBits-2:0], code[i]};
        if (dec_left > 0) dec_left = dec_left - 1'b1;
        if (dec_left == 0) begin
          mapped = ({16'd0, dec_run} << k) + {17'd0, dec_acc};
          if (mapped[0]) begin
            half = (mapped + 32'd1) >> 1;
            found[n].sample = SampleBits'(32'd0 - half);
          end else begin
            found[n].sample = mapped[SampleBits:1];
          end
          found[n].ovf = dec_ovf;
          found[n].last = 1'b0;
          n++;
          clear_decode_state();
        end
      end
    end
    for (i = 0; i < n; i++) begin
      if (i == n - 1) found[i].last = 1'b1;
      expected_samples.push_back(found[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_bytes.pop_front();
          if (idle_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 18);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        samples_seen++;
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected sample", $signed(m_axis_tdata), 0);
        end else begin
          want = expected_samples.pop_front();
          if (m_axis_tdata !== want.sample)
            report_mismatch("sample", $signed(m_axis_tdata), $signed(want.sample));
          if (m_axis_tuser !== want.ovf)
            report_mismatch("run_overflow", m_axis_tuser, want.ovf);
          if (m_axis_tlast !== want.last)
            report_mismatch("last_in_byte", m_axis_tlast, want.last);
        end
      end
      // one long hold so the byte side backs up
      if (!long_hold_done && pending_bytes.size() >= LongHoldBacklog) begin
        long_hold_done = 1'b1;
        recv_hold = LongHoldCycles;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        recv_hold = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (pending_bytes.size() > 0 || s_axis_tvalid || expected_samples.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_rice_k(input logic [KBits-1:0] k);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= k;
    rice_k_cur = k;
    clear_decode_state();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly random bytes, with zero bursts that stretch the unary run
  task automatic push_random(input int count);
    int i;
    int j;
    int burst;
    i = 0;
    while (i < count) begin
      case ($urandom_range(0, 9))
        0: begin
          burst = $urandom_range(1, 6);
          for (j = 0; j < burst && i < count; j++) begin
            pending_bytes.push_back(8'h00);
            i++;
          end
        end
        1: begin
          pending_bytes.push_back(8'hFF);
          i++;
        end
        default: begin
          pending_bytes.push_back(ByteBits'($urandom_range(0, 255)));
          i++;
        end
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of rice_k
    pending_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hC3, 8'h7E};
    drain();

    // largest k: saturated run, extreme samples
    set_rice_k(4'd15);
    pending_bytes = '{8'h00, 8'h00, 8'h7F, 8'hFF, 8'hC0, 8'h40, 8'h00, 8'h7F};
    drain();

    // k of zero behaves as one
    set_rice_k(4'd0);
    pending_bytes = '{8'hFF, 8'h24};
    drain();

    set_rice_k(4'd2);
    push_random(15);
    drain();
    push_random(15);
    drain();

    set_rice_k(4'd15);
    push_random(25);
    drain();

    set_rice_k(KBits'($urandom_range(1, 15)));
    push_random(25);
    drain();

    // closing stretch at full rate
    idle_on = 1'b0;
    set_rice_k(4'd1);
    push_random(20);
    drain();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== rice_decoder_signed_samples.f =====
hw/rtl/rdss_pkg.sv
hw/rtl/rdss_front.sv
hw/rtl/rdss_queue.sv
hw/rtl/rdss_back.sv
hw/rtl/rice_decoder_signed_samples.sv
bench/rice_decoder_signed_samples_test.sv
